// ===== hdl/ycc_pkg.sv =====
package ycc_pkg;

	// Q12 coefficients, rounded to nearest
	localparam int unsigned QShift = 12;
	localparam logic [11:0] K_INV115 = 12'd3562;   // 1/1.15
	localparam int unsigned ChromaOffset = 15;

	localparam int unsigned AccW = 25;             // signed accumulator width
	localparam logic signed [AccW-1:0] K_CR_R  = 25'sd5747;    // 1.403
	localparam logic signed [AccW-1:0] K_OFF_R = 25'sd735232;  // 179.5
	localparam logic signed [AccW-1:0] K_CB_G  = 25'sd1410;    // 0.3443
	localparam logic signed [AccW-1:0] K_OFF_G = 25'sd555008;  // 135.5
	localparam logic signed [AccW-1:0] K_CR_G  = 25'sd2926;    // 0.7144
	localparam logic signed [AccW-1:0] K_OFF_B = 25'sd929792;  // 227.0
	localparam logic signed [AccW-1:0] K_CB_B  = 25'sd7262;    // 1.773

	typedef logic signed [AccW-1:0] acc_t;

	// Rescaled pixel handed from the chroma stage to the matrix stage
	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] blue_diff;
		logic [7:0] red_diff;
	} pix_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// trunc(x / 1.15) + 15, range 15..236
	function automatic logic [7:0] rescale(input logic [7:0] raw);
		logic [19:0] prod;
		prod = 20'(raw) * 20'(K_INV115);
		return prod[19:12] + 8'(ChromaOffset);
	endfunction

	// Truncate Q12 toward zero and clamp to 0..255
	function automatic logic [7:0] sat_byte(input acc_t q);
		logic [AccW-QShift-1:0] whole;
		whole = q[AccW-1:QShift];
		if (q[AccW-1]) begin
			return 8'd0;
		end else if (whole > (AccW-QShift)'(255)) begin
			return 8'd255;
		end else begin
			return whole[7:0];
		end
	endfunction

endpackage

// ===== hdl/ycc_stream_if.sv =====
interface ycc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] chroma_byte;
	logic [7:0] luma_byte;
	logic       frame_start;

	modport source (output valid, chroma_byte, luma_byte, frame_start, input ready);
	modport sink   (input valid, chroma_byte, luma_byte, frame_start, output ready);
endinterface

interface ycc_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== hdl/ycc_chroma_stage.sv =====
module ycc_chroma_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    chroma_byte,
	input  logic [7:0]    luma_byte,
	input  logic          frame_start,
	output logic          valid_s1,
	input  logic          next_ready,
	output ycc_pkg::pix_t pix_s1
);
	import ycc_pkg::*;

	logic       chroma_phase_q;
	logic [7:0] held_blue_diff_q;
	logic [7:0] held_red_diff_q;
	logic       accept;
	logic       phase_next;
	logic [7:0] chroma_scaled;
	logic [7:0] blue_next;
	logic [7:0] red_next;

	assign in_ready      = !valid_s1 || next_ready;
	assign accept        = in_valid && in_ready;
	assign phase_next    = frame_start ? 1'b1 : !chroma_phase_q;
	assign chroma_scaled = rescale(chroma_byte);
	assign blue_next     = phase_next ? chroma_scaled : held_blue_diff_q;
	assign red_next      = phase_next ? held_red_diff_q : chroma_scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_phase_q   <= 1'b0;
			held_blue_diff_q <= 8'd0;
			held_red_diff_q  <= 8'd0;
			valid_s1         <= 1'b0;
		end else begin
			if (accept) begin
				chroma_phase_q   <= phase_next;
				held_blue_diff_q <= blue_next;
				held_red_diff_q  <= red_next;
				valid_s1         <= 1'b1;
			end else if (next_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1.luma      <= rescale(luma_byte);
			pix_s1.blue_diff <= blue_next;
			pix_s1.red_diff  <= red_next;
		end
	end

	a_frame_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> chroma_phase_q)
		else $error("phase not set to one after frame start");

	a_phase_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !frame_start |=> chroma_phase_q != $past(chroma_phase_q))
		else $error("phase failed to toggle");

	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(held_blue_diff_q) && $stable(held_red_diff_q)
			&& $stable(chroma_phase_q))
		else $error("held chroma changed without a transaction");

endmodule

// ===== hdl/ycc_matrix_stage.sv =====
module ycc_matrix_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ycc_pkg::pix_t pix_s1,
	output logic          valid_s2,
	input  logic          out_ready,
	output ycc_pkg::rgb_t rgb_s2
);
	import ycc_pkg::*;

	acc_t luma_q12;
	acc_t cb_s;
	acc_t cr_s;
	acc_t red_acc;
	acc_t green_acc;
	acc_t blue_acc;
	logic accept;

	assign in_ready = !valid_s2 || out_ready;
	assign accept   = in_valid && in_ready;

	assign luma_q12 = acc_t'({pix_s1.luma, 12'd0});
	assign cb_s     = acc_t'(pix_s1.blue_diff);
	assign cr_s     = acc_t'(pix_s1.red_diff);

	assign red_acc   = K_CR_R * cr_s - K_OFF_R + luma_q12;
	assign green_acc = K_OFF_G + luma_q12 - K_CB_G * cb_s - K_CR_G * cr_s;
	assign blue_acc  = luma_q12 - K_OFF_B + K_CB_B * cb_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rgb_s2.red   <= sat_byte(red_acc);
			rgb_s2.green <= sat_byte(green_acc);
			rgb_s2.blue  <= sat_byte(blue_acc);
		end
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s2)
		else $error("result register not loaded");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_ready && !accept |=> !valid_s2)
		else $error("result repeated after transaction");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(rgb_s2))
		else $error("stalled result changed");

endmodule

// ===== hdl/ycbcr422_to_rgb_converter.sv =====
// 4:2:2 YCbCr to RGB converter. Each input transaction carries one pixel: a
// chroma byte (Cb and Cr on alternating pixels) and a luma byte; each
// produces exactly one RGB transaction. A one-bit phase toggles per pixel
// and is forced so the pixel flagged frame_start loads Cb; the other chroma
// component keeps its last value (zero after reset). Bytes are rescaled as
// trunc(x/1.15)+15, then mapped to RGB in Q12 fixed point, truncated and
// clamped to 0..255. Throughput is one pixel per clock while the output is
// not stalled. The first register holds the rescaled luma and chroma, and
// the second holds the saturated RGB result after the constant-coefficient
// multiply-add. Each stage accepts a new transaction while its neighbor
// downstream is taking the held one, so back pressure costs no bubbles.
module ycbcr422_to_rgb_converter (
	input logic    clk,
	input logic    arst_n,
	ycc_pix_if.sink  pix,
	ycc_rgb_if.source rgb
);
	import ycc_pkg::*;

	logic  valid_s1;
	logic  ready_s2;
	pix_t  pix_s1;
	rgb_t  rgb_s2;

	// Stage 1: phase tracking, held chroma, rescale
	ycc_chroma_stage u_chroma (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pix.valid),
		.in_ready    (pix.ready),
		.chroma_byte (pix.chroma_byte),
		.luma_byte   (pix.luma_byte),
		.frame_start (pix.frame_start),
		.valid_s1    (valid_s1),
		.next_ready  (ready_s2),
		.pix_s1      (pix_s1)
	);

	// Stage 2: color matrix and saturation into the result register
	ycc_matrix_stage u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (ready_s2),
		.pix_s1    (pix_s1),
		.valid_s2  (rgb.valid),
		.out_ready (rgb.ready),
		.rgb_s2    (rgb_s2)
	);

	// Drive the result payload from the stage 2 register
	assign rgb.red   = rgb_s2.red;
	assign rgb.green = rgb_s2.green;
	assign rgb.blue  = rgb_s2.blue;

endmodule
